// File: sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: sv/scsi_pkg.sv
// package for the sorted chunk spatial index: types, codes and constants
// no dependencies
package scsi_pkg;
  localparam int unsigned CapacityDef = 64;
  localparam logic [62:0] ChunkSizeRst = 63'd1048576;
  localparam logic signed [63:0] I32Top = 64'sd2147483647;
  localparam logic signed [63:0] I32Bot = -64'sd2147483648;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_START, S_DIV_WAIT, S_SRCH_RD, S_SRCH_CMP, S_CHK_RD, S_CHK_CMP,
    S_SHIFT_RD, S_SHIFT_WR, S_REM_RD, S_REM_CHK, S_DONE
  } fsm_t;

  // one stored entry, 416 bits
  typedef struct packed {
    logic [63:0] posz;
    logic [63:0] posy;
    logic [63:0] posx;
    logic [63:0] node;
    logic [63:0] strk;
    logic [31:0] cz;
    logic [31:0] cy;
    logic [31:0] cx;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // divider control and status
  typedef struct packed {
    logic start;
    logic signed [63:0] dividend;
    logic [62:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic [31:0] chunk;
  } div_rsp_t;
endpackage

// File: sv/scsi_ram.sv
// generic single-port ram with registered read
// no dependencies
module scsi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // read before write (old word on a write), read registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: sv/scsi_div.sv
// restoring bit-serial floor divider with signed 32-bit clamp
// depends on scsi_pkg
module scsi_div (
  input  logic              clk,
  input  logic              rst_n,
  input  scsi_pkg::div_req_t req,
  output scsi_pkg::div_rsp_t rsp
);
  import scsi_pkg::*;

  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [62:0] dvs_r, dvs_nxt;
  logic        neg_r, neg_nxt;
  logic        zero_r, zero_nxt;
  logic [31:0] res_r, res_nxt;
  logic [64:0] trial;
  logic [63:0] rem_sh;
  logic [64:0] mag_q;
  logic signed [65:0] fq;

  assign rsp.busy  = (cnt_r != 7'd0);
  assign rsp.chunk = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    res_r  <= res_nxt;
  end

  // one quotient bit per cycle on the magnitude, then floor and clamp
  always_comb begin
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    res_nxt  = res_r;
    rem_sh   = {rem_r[62:0], quo_r[63]};
    trial    = {1'b0, rem_sh} - {2'b0, dvs_r};
    mag_q    = '0;
    fq       = '0;
    if (req.start) begin
      cnt_nxt  = 7'd64;
      neg_nxt  = req.dividend[63];
      quo_nxt  = req.dividend[63] ? (~req.dividend + 64'd1) : req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      zero_nxt = (req.divisor == '0);
    end else if (cnt_r != 7'd0) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        mag_q = {1'b0, quo_nxt};
        if (neg_r) begin
          fq = -$signed({1'b0, mag_q}) - ((rem_nxt != '0) ? 66'sd1 : 66'sd0);
        end else begin
          fq = $signed({1'b0, mag_q});
        end
        if (zero_r) begin
          res_nxt = '0;
        end else if (fq > 66'sd2147483647) begin
          res_nxt = I32Top[31:0];
        end else if (fq < -66'sd2147483648) begin
          res_nxt = I32Bot[31:0];
        end else begin
          res_nxt = fq[31:0];
        end
      end
    end
  end
endmodule

// File: sv/sorted_chunk_spatial_index_top.sv
// Sorted chunk spatial index. Each beat is one operation (insert/update, remove a struct, clear,
// no-op) and yields one result beat. Insert runs three 64-step serial divisions on one shared
// divider, then a binary search over the entry ram with a read and a compare per probe, then a
// shift of up to CAPACITY-1 entries with a read and a write each; remove sweeps all held entries
// unless its struct key is zero; clear only resets the entry count. One operation is worked at a
// time, and in_tready is low meanwhile and until the result beat has been taken. The single-port
// entry ram sets the search and shift pace. No clearing pass after reset.
module sorted_chunk_spatial_index_top #(
  parameter int unsigned CAPACITY = scsi_pkg::CapacityDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, struct_key, node_key from bit 0 up
  input  logic [319:0] in_tdata,
  // mode
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, slot, removed_count, entry_count, refusals from bit 0 up; zero pad
  output logic [55:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [0:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import scsi_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = AW + 1;

  fsm_t state_r, state_nxt;
  logic [62:0] csize_r;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [31:0] refs_r, refs_nxt;
  logic [319:0] inp_r;
  logic [31:0] cx_r, cy_r, cz_r, cx_nxt, cy_nxt, cz_nxt;
  logic [1:0] dix_r, dix_nxt;
  logic [CW-1:0] lo_r, hi_r, k_r, w_r, lo_nxt, hi_nxt, k_nxt, w_nxt;
  logic [6:0] rmv_r, rmv_nxt;
  logic [2:0] st_r, st_nxt;
  logic [5:0] slot_r, slot_nxt;
  logic ov_r, ov_nxt;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  entry_t ram_wd, ram_rd, key_e;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [CW-1:0] mid;
  logic k_lt, k_eq;

  logic [63:0] px, py, pz, sk, nk;
  assign px = inp_r[63:0];
  assign py = inp_r[127:64];
  assign pz = inp_r[191:128];
  assign sk = inp_r[255:192];
  assign nk = inp_r[319:256];

  scsi_ram #(.Width(EntryW), .Depth(CAPACITY)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  scsi_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 1'b0) ? {1'b0, csize_r} : 64'd0;

  // handshake, input held off while a result beat waits
  assign in_tready  = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, refs_r, 7'(fill_r), rmv_r, slot_r, st_r};

  assign key_e = '{posz: pz, posy: py, posx: px, node: nk, strk: sk,
                   cz: cz_r, cy: cy_r, cx: cx_r};

  // composite key compare against the ram read word
  always_comb begin
    k_eq = (key_e.cx == ram_rd.cx) && (key_e.cy == ram_rd.cy) && (key_e.cz == ram_rd.cz) &&
           (key_e.strk == ram_rd.strk) && (key_e.node == ram_rd.node);
    if (key_e.cx != ram_rd.cx) k_lt = $signed(key_e.cx) < $signed(ram_rd.cx);
    else if (key_e.cy != ram_rd.cy) k_lt = $signed(key_e.cy) < $signed(ram_rd.cy);
    else if (key_e.cz != ram_rd.cz) k_lt = $signed(key_e.cz) < $signed(ram_rd.cz);
    else if (key_e.strk != ram_rd.strk) k_lt = key_e.strk < ram_rd.strk;
    else k_lt = key_e.node < ram_rd.node;
  end

  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      csize_r <= ChunkSizeRst;
      fill_r  <= '0;
      refs_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      refs_r  <= refs_nxt;
      ov_r    <= ov_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0) begin
        csize_r <= cfg_pwdata[62:0];
      end
    end
    if (in_tvalid && in_tready) begin
      inp_r <= in_tdata;
    end
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt;
    dix_r <= dix_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; k_r <= k_nxt; w_r <= w_nxt;
    rmv_r <= rmv_nxt; st_r <= st_nxt; slot_r <= slot_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; refs_nxt = refs_r; ov_nxt = ov_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r; dix_nxt = dix_r;
    lo_nxt = lo_r; hi_nxt = hi_r; k_nxt = k_r; w_nxt = w_r; rmv_nxt = rmv_r;
    st_nxt = st_r; slot_nxt = slot_r;
    ram_we = 1'b0; ram_addr = '0; ram_wd = ram_rd;
    dreq.start = 1'b0; dreq.divisor = csize_r; dreq.dividend = $signed(px);
    case (dix_r)
      2'd1: dreq.dividend = $signed(py);
      2'd2: dreq.dividend = $signed(pz);
      default: dreq.dividend = $signed(px);
    endcase
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          rmv_nxt = '0; slot_nxt = '0; dix_nxt = 2'd0;
          lo_nxt = '0; hi_nxt = fill_r; w_nxt = '0; k_nxt = '0;
          case (mode_t'(in_tuser))
            MODE_INSERT: state_nxt = S_DIV_START;
            MODE_REMOVE: begin
              st_nxt = ST_REMOVED;
              state_nxt = (in_tdata[255:192] != 64'd0) ? S_REM_RD : S_DONE;
            end
            MODE_CLEAR: begin
              st_nxt = ST_CLEARED; fill_nxt = '0; state_nxt = S_DONE;
            end
            default: begin
              st_nxt = ST_REMOVED; state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_DIV_START: begin
        dreq.start = 1'b1; state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!drsp.busy) begin
          case (dix_r)
            2'd0: cx_nxt = drsp.chunk;
            2'd1: cy_nxt = drsp.chunk;
            default: cz_nxt = drsp.chunk;
          endcase
          if (dix_r == 2'd2) begin
            state_nxt = S_SRCH_RD;
          end else begin
            dix_nxt = dix_r + 2'd1; state_nxt = S_DIV_START;
          end
        end
      end
      S_SRCH_RD: begin
        ram_addr = mid[AW-1:0];
        state_nxt = (lo_r < hi_r) ? S_SRCH_CMP : S_CHK_RD;
      end
      S_SRCH_CMP: begin
        if (k_lt || k_eq) hi_nxt = mid;
        else lo_nxt = mid + 1'b1;
        state_nxt = S_SRCH_RD;
      end
      S_CHK_RD: begin
        ram_addr = lo_r[AW-1:0];
        state_nxt = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        ram_addr = lo_r[AW-1:0];
        if (lo_r < fill_r && k_eq) begin
          ram_we = 1'b1; ram_wd = ram_rd;
          ram_wd.posx = px; ram_wd.posy = py; ram_wd.posz = pz;
          st_nxt = ST_UPDATED; slot_nxt = 6'(lo_r); state_nxt = S_DONE;
        end else if (fill_r >= CW'(CAPACITY)) begin
          refs_nxt = refs_r + 32'd1; st_nxt = ST_REFUSED; state_nxt = S_DONE;
        end else begin
          k_nxt = fill_r; state_nxt = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (k_r > lo_r) begin
          ram_addr = AW'(k_r - 1'b1); state_nxt = S_SHIFT_WR;
        end else begin
          ram_addr = lo_r[AW-1:0]; ram_we = 1'b1; ram_wd = key_e;
          fill_nxt = fill_r + 1'b1; st_nxt = ST_INSERTED; slot_nxt = 6'(lo_r);
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        ram_addr = k_r[AW-1:0]; ram_we = 1'b1; ram_wd = ram_rd;
        k_nxt = k_r - 1'b1; state_nxt = S_SHIFT_RD;
      end
      // compaction: read k, write at w when kept
      S_REM_RD: begin
        if (k_r < fill_r) begin
          ram_addr = k_r[AW-1:0]; state_nxt = S_REM_CHK;
        end else begin
          fill_nxt = w_r; state_nxt = S_DONE;
        end
      end
      S_REM_CHK: begin
        ram_addr = w_r[AW-1:0];
        if (ram_rd.strk == sk) begin
          rmv_nxt = rmv_r + 7'd1;
        end else begin
          ram_we = (w_r != k_r); ram_wd = ram_rd; w_nxt = w_r + 1'b1;
        end
        k_nxt = k_r + 1'b1; state_nxt = S_REM_RD;
      end
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// File: sv/scsi_checker.sv
// port-level checker for the sorted chunk spatial index, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module scsi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);
  `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready after accept")
  `CHK_IMPL(a_no_take_while_out, clk, rst_n, out_tvalid && !out_tready, !in_tready, "input taken while result waits")
  `CHK_IMPL(a_status_range, clk, rst_n, out_tvalid, out_tdata[2:0] <= 3'd4, "bad status")
  `CHK_IMPL(a_slot_zero, clk, rst_n, out_tvalid && out_tdata[2:0] >= 3'd2, out_tdata[8:3] == 6'd0, "slot not zero")
  `CHK_IMPL(a_entry_max, clk, rst_n, out_tvalid, out_tdata[22:16] <= 7'd64, "entry count too large")
endmodule

bind sorted_chunk_spatial_index_top scsi_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// File: tb/sv/sorted_chunk_spatial_index_top_tb.sv
// self-checking testbench for the sorted chunk spatial index top level
// depends on scsi_pkg and sorted_chunk_spatial_index_top
`timescale 1ns / 1ps

class chunk_index_board;
  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [6:0]  removed;
    logic [6:0]  held;
    logic [31:0] refusals;
  } outcome_t;

  scsi_pkg::entry_t tbl [64];
  int unsigned      fill;
  logic [31:0]      refusal_cnt;
  logic [62:0]      chunk_size;
  outcome_t         pending_q[$];
  int               errors;

  function new();
    fill = 0;
    refusal_cnt = 0;
    chunk_size = scsi_pkg::ChunkSizeRst;
    errors = 0;
  endfunction

  // floor division by the chunk edge, saturated to signed 32 bits; zero for a zero edge
  function logic [31:0] floor_chunk(logic signed [63:0] a);
    longint q, d, r;
    if (chunk_size == 0) return 32'd0;
    d = longint'({1'b0, chunk_size});
    q = a / d;
    r = a % d;
    if (r != 0 && a < 0) q = q - 1;
    if (q > scsi_pkg::I32Top) q = scsi_pkg::I32Top;
    if (q < scsi_pkg::I32Bot) q = scsi_pkg::I32Bot;
    return q[31:0];
  endfunction

  // -1, 0, 1 as the probe key sorts below, equal to, above entry i
  function int order_vs(scsi_pkg::entry_t k, int unsigned i);
    if (k.cx != tbl[i].cx) return ($signed(k.cx) < $signed(tbl[i].cx)) ? -1 : 1;
    if (k.cy != tbl[i].cy) return ($signed(k.cy) < $signed(tbl[i].cy)) ? -1 : 1;
    if (k.cz != tbl[i].cz) return ($signed(k.cz) < $signed(tbl[i].cz)) ? -1 : 1;
    if (k.strk != tbl[i].strk) return (k.strk < tbl[i].strk) ? -1 : 1;
    if (k.node != tbl[i].node) return (k.node < tbl[i].node) ? -1 : 1;
    return 0;
  endfunction

  function void note_op(scsi_pkg::mode_t mode, logic [319:0] d);
    scsi_pkg::entry_t k;
    outcome_t o;
    int unsigned lo, hi, mid, w;
    o = '0;
    o.status = scsi_pkg::ST_REMOVED;
    k.posx = d[63:0];
    k.posy = d[127:64];
    k.posz = d[191:128];
    k.strk = d[255:192];
    k.node = d[319:256];
    case (mode)
      scsi_pkg::MODE_INSERT: begin
        k.cx = floor_chunk(k.posx);
        k.cy = floor_chunk(k.posy);
        k.cz = floor_chunk(k.posz);
        lo = 0;
        hi = fill;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (order_vs(k, mid) <= 0) hi = mid;
          else lo = mid + 1;
        end
        if (lo < fill && order_vs(k, lo) == 0) begin
          tbl[lo].posx = k.posx;
          tbl[lo].posy = k.posy;
          tbl[lo].posz = k.posz;
          o.status = scsi_pkg::ST_UPDATED;
          o.slot = lo[5:0];
        end else if (fill >= 64) begin
          refusal_cnt = refusal_cnt + 1;
          o.status = scsi_pkg::ST_REFUSED;
        end else begin
          for (int unsigned j = fill; j > lo; j--) tbl[j] = tbl[j-1];
          tbl[lo] = k;
          fill++;
          o.status = scsi_pkg::ST_INSERTED;
          o.slot = lo[5:0];
        end
      end
      scsi_pkg::MODE_REMOVE: begin
        if (k.strk != 0) begin
          w = 0;
          for (int unsigned r = 0; r < fill; r++) begin
            if (tbl[r].strk == k.strk) o.removed++;
            else begin
              tbl[w] = tbl[r];
              w++;
            end
          end
          fill = w;
        end
      end
      scsi_pkg::MODE_CLEAR: begin
        fill = 0;
        o.status = scsi_pkg::ST_CLEARED;
      end
      default: ;
    endcase
    o.held = fill[6:0];
    o.refusals = refusal_cnt;
    pending_q.push_back(o);
  endfunction

  function void check_result(logic [55:0] d);
    outcome_t e, a;
    a = {d[2:0], d[8:3], d[15:9], d[22:16], d[54:23]};
    if (pending_q.size() == 0) begin
      $display("%0t: result beat with nothing expected, got %h", $time, a);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (a.status !== e.status) begin
      $display("%0t: status expected %0d got %0d", $time, e.status, a.status);
      errors++;
    end
    if (a.slot !== e.slot) begin
      $display("%0t: slot expected %0d got %0d", $time, e.slot, a.slot);
      errors++;
    end
    if (a.removed !== e.removed) begin
      $display("%0t: removed_count expected %0d got %0d", $time, e.removed, a.removed);
      errors++;
    end
    if (a.held !== e.held) begin
      $display("%0t: entry_count expected %0d got %0d", $time, e.held, a.held);
      errors++;
    end
    if (a.refusals !== e.refusals) begin
      $display("%0t: refusals expected %0d got %0d", $time, e.refusals, a.refusals);
      errors++;
    end
  endfunction
endclass

module sorted_chunk_spatial_index_top_tb;
  import scsi_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [319:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [55:0]  out_tdata;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [0:0]   cfg_paddr;
  logic [63:0]  cfg_pwdata;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  chunk_index_board board;
  bit     calm;
  bit     hold_req;
  bit     hold_done;
  int     quiet_cycles = 0;
  logic [63:0] struct_pool [6] = '{64'd1, 64'd2, 64'd3, 64'd5,
                                   64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000};

  sorted_chunk_spatial_index_top i_dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready = 0;
        repeat (3000) @(negedge clk);
        hold_done = 1;
      end
      out_tready = calm || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("[sorted_chunk_spatial_index_top] ERROR");
      $finish;
    end
  end

  task automatic send_op(mode_t mode, logic [63:0] px, logic [63:0] py, logic [63:0] pz,
                         logic [63:0] sk, logic [63:0] nk);
    if (!calm && $urandom_range(99) < 12) begin
      @(negedge clk);
      in_tvalid = 0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1;
    in_tuser = mode;
    in_tdata = {nk, sk, pz, py, px};
    do @(posedge clk); while (!in_tready);
    board.note_op(mode, in_tdata);
  endtask

  task automatic write_chunk_size(logic [62:0] v);
    @(negedge clk);
    in_tvalid = 0;
    cfg_psel = 1;
    cfg_pwrite = 1;
    cfg_paddr = 0;
    cfg_pwdata = {1'b0, v};
    cfg_penable = 0;
    @(negedge clk);
    cfg_penable = 1;
    @(posedge clk);
    board.chunk_size = v;
    @(negedge clk);
    cfg_psel = 0;
    cfg_penable = 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // positions in the chunks around zero so keys repeat, else extremes or anything
  function automatic logic [63:0] pick_pos();
    longint cs, ci;
    cs = longint'({1'b0, board.chunk_size});
    case ($urandom_range(9))
      0: return 64'h7FFF_FFFF_FFFF_FFFF;
      1: return 64'h8000_0000_0000_0000;
      2, 3: return rnd64();
      default: begin
        ci = $signed($urandom_range(6)) - 3;
        if (cs == 0) return rnd64();
        return ci * cs + longint'(rnd64() & 64'h7FFF_FFFF_FFFF_FFFF) % cs;
      end
    endcase
  endfunction

  task automatic random_ops(int n, bit pause_mid, bit hold_mid);
    int sel;
    logic [63:0] nk;
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 3) hold_req = 1;
      if (pause_mid && i == n / 2) drain();
      sel = $urandom_range(99);
      nk = ($urandom_range(3) == 0) ? rnd64() : 64'($urandom_range(40));
      if (sel < 78)
        send_op(MODE_INSERT, pick_pos(), pick_pos(), pick_pos(),
                ($urandom_range(9) == 0) ? rnd64() : struct_pool[$urandom_range(5)], nk);
      else if (sel < 90)
        send_op(MODE_REMOVE, rnd64(), rnd64(), rnd64(),
                ($urandom_range(5) == 0) ? rnd64() : struct_pool[$urandom_range(5)], rnd64());
      else if (sel < 93)
        send_op(MODE_CLEAR, rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
      else if (sel < 96)
        send_op(MODE_NOP, rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
      else
        send_op(MODE_REMOVE, rnd64(), rnd64(), rnd64(), 64'd0, rnd64());
    end
  endtask

  initial begin
    logic [63:0] lo_k, hi_k;
    board = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = MODE_INSERT;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = 0;
    cfg_pwdata = '0;
    calm = 0;
    hold_req = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes, saturation, update, every mode
    lo_k = 64'd0;
    hi_k = 64'hFFFF_FFFF_FFFF_FFFF;
    send_op(MODE_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'd0, lo_k, lo_k);
    send_op(MODE_INSERT, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, hi_k, hi_k, hi_k);
    send_op(MODE_INSERT, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, hi_k, hi_k, hi_k);
    send_op(MODE_INSERT, -64'sd1, 64'd1048575, 64'd1048576, 64'd7, 64'd1);
    send_op(MODE_INSERT, -64'sd1048576, -64'sd1048577, 64'd5, 64'd7, 64'd2);
    send_op(MODE_INSERT, -64'sd2, 64'd3, 64'd1048577, 64'd7, 64'd1);
    send_op(MODE_REMOVE, hi_k, hi_k, hi_k, 64'd0, hi_k);
    send_op(MODE_NOP, hi_k, hi_k, hi_k, hi_k, hi_k);
    send_op(MODE_REMOVE, 64'd0, 64'd0, 64'd0, 64'd7, 64'd0);
    send_op(MODE_REMOVE, 64'd0, 64'd0, 64'd0, hi_k, 64'd0);
    send_op(MODE_CLEAR, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
    drain();

    // zero chunk edge: every chunk coordinate is zero
    write_chunk_size(63'd0);
    send_op(MODE_INSERT, hi_k, 64'h8000_0000_0000_0000, 64'd12345, 64'd2, 64'd9);
    send_op(MODE_INSERT, 64'd1, 64'd2, 64'd3, 64'd2, 64'd9);
    send_op(MODE_INSERT, 64'd4, 64'd5, 64'd6, 64'd1, 64'd9);
    drain();

    write_chunk_size(63'd1048576);
    random_ops(330, 0, 0);
    drain();
    write_chunk_size(63'd1);
    random_ops(330, 0, 1);
    drain();
    write_chunk_size(63'd196608);
    calm = 1;
    random_ops(300, 0, 0);
    calm = 0;
    drain();
    write_chunk_size(63'h7FFF_FFFF_FFFF_FFFF);
    random_ops(330, 1, 0);
    drain();
    write_chunk_size(63'd0);
    random_ops(300, 0, 0);
    drain();
    write_chunk_size(63'd12345);
    random_ops(330, 0, 0);
    drain();

    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.pending_q.size() == 0)
      $display("[sorted_chunk_spatial_index_top] OK");
    else
      $display("[sorted_chunk_spatial_index_top] ERROR");
    $finish;
  end
endmodule

// File: sim.f
+incdir+sv
sv/scsi_pkg.sv
sv/scsi_ram.sv
sv/scsi_div.sv
sv/sorted_chunk_spatial_index_top.sv
sv/scsi_checker.sv
tb/sv/sorted_chunk_spatial_index_top_tb.sv
